// ----- rtl/wpm_pkg.sv -----
`default_nettype none

package wpm_pkg;

    // action codes
    localparam logic [1:0] ACT_RESTART = 2'd0;
    localparam logic [1:0] ACT_PATTERN = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    localparam logic [7:0]  WILDCARD_BYTE = 8'd42;
    localparam logic [19:0] COUNT_LIMIT   = 20'hFFFFF;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
    } wpm_in_t;

    typedef struct packed {
        logic        match_found;
        logic [19:0] start_position;
        logic [19:0] match_count;
    } wpm_out_t;

    // control half of a queue entry; the lane vector travels beside it
    typedef struct packed {
        logic        clear;
        logic [19:0] start_position;
    } wpm_tag_t;

endpackage

`default_nettype wire

// ----- rtl/wpm_ram.sv -----
`default_nettype none

module wpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wpm_front.sv -----
`default_nettype none

module wpm_front
    import wpm_pkg::*;
#(
    parameter int          PATTERN_MAX = 64,
    parameter logic [31:0] TEXT_MAX    = 32'd1048575
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire wpm_in_t                item,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [6:0]             cfg_data,
    input  wire logic                   q_full,
    output logic                        push,
    output wpm_tag_t                    push_tag,
    output logic [PATTERN_MAX-1:0]      push_lanes
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [19:0] SEEN_LIMIT =
        (TEXT_MAX < {12'd0, COUNT_LIMIT}) ? TEXT_MAX[19:0] : COUNT_LIMIT;

    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [LW-1:0] load_ptr_reg;
    logic [19:0]   seen_reg;
    logic [19:0]   seen_next;
    logic [7:0]    tw_reg [PATTERN_MAX];
    logic [7:0]    tw_next [PATTERN_MAX];
    logic [7:0]    ap_reg [PATTERN_MAX];   // pattern, reversed to window order

    logic          sweep_active_reg;
    logic [LW-1:0] sweep_idx_reg;
    logic          rd_pend_reg;
    logic [IW-1:0] rd_lane_reg;
    logic          sweep_rd;
    logic [LW-1:0] sweep_addr;
    logic [7:0]    ram_rdata;

    logic          accept;
    logic          is_restart;
    logic          is_pattern;
    logic          is_text;
    logic          store_wr;
    logic          ap_wr;
    logic [LW-1:0] ap_idx;
    logic          cfg_wr;

    assign cfg_ready  = !sweep_active_reg && !rd_pend_reg;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign item_stall = q_full || sweep_active_reg || rd_pend_reg || cfg_valid;
    assign accept     = item_valid && !item_stall;
    assign is_restart = accept && (item.action == ACT_RESTART);
    assign is_pattern = accept && (item.action == ACT_PATTERN);
    assign is_text    = accept && (item.action == ACT_TEXT);

    assign store_wr   = is_pattern && (load_ptr_reg < LW'(PATTERN_MAX));
    assign ap_wr      = is_pattern && (load_ptr_reg < len_reg);
    assign ap_idx     = len_reg - LW'(1) - load_ptr_reg;

    assign sweep_rd   = sweep_active_reg && (sweep_idx_reg < len_reg);
    assign sweep_addr = len_reg - LW'(1) - sweep_idx_reg;

    always_comb
    begin
        if (cfg_data == 7'd0)
        begin
            len_next = LW'(1);
        end
        else if (32'(cfg_data) > 32'(PATTERN_MAX))
        begin
            len_next = LW'(PATTERN_MAX);
        end
        else
        begin
            len_next = LW'(cfg_data);
        end
    end

    wpm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (store_wr),
        .waddr (load_ptr_reg[IW-1:0]),
        .wdata (item.byte_value),
        .re    (sweep_rd),
        .raddr (sweep_addr[IW-1:0]),
        .rdata (ram_rdata)
    );

    // window after the incoming byte shifts in; lane k against aligned pattern k
    assign tw_next[0] = item.byte_value;
    for (genvar k = 1; k < PATTERN_MAX; k++)
    begin : g_shift
        assign tw_next[k] = tw_reg[k-1];
    end

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_lane
        assign push_lanes[k] = (LW'(k) >= len_reg)
                            || (ap_reg[k] == WILDCARD_BYTE)
                            || (tw_next[k] == WILDCARD_BYTE)
                            || (ap_reg[k] == tw_next[k]);
    end

    assign seen_next = (seen_reg < SEEN_LIMIT) ? seen_reg + 20'd1 : seen_reg;

    assign push                    = is_restart || (is_text && (seen_next >= 20'(len_reg)));
    assign push_tag.clear          = is_restart;
    assign push_tag.start_position = seen_next - 20'(len_reg) + 20'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= LW'(1);
            sweep_active_reg <= 1'b0;
            sweep_idx_reg    <= '0;
            rd_pend_reg      <= 1'b0;
            rd_lane_reg      <= '0;
        end
        else
        begin
            rd_pend_reg <= sweep_rd;
            rd_lane_reg <= sweep_idx_reg[IW-1:0];
            if (cfg_wr)
            begin
                len_reg          <= len_next;
                sweep_active_reg <= 1'b1;
                sweep_idx_reg    <= '0;
            end
            else if (sweep_active_reg)
            begin
                if (sweep_rd)
                begin
                    sweep_idx_reg <= sweep_idx_reg + LW'(1);
                end
                else
                begin
                    sweep_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg <= '0;
            seen_reg     <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                tw_reg[k] <= '0;
            end
        end
        else if (is_restart)
        begin
            load_ptr_reg <= '0;
            seen_reg     <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                tw_reg[k] <= '0;
            end
        end
        else if (store_wr)
        begin
            load_ptr_reg <= load_ptr_reg + LW'(1);
        end
        else if (is_text)
        begin
            seen_reg <= seen_next;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                tw_reg[k] <= tw_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            ap_reg[rd_lane_reg] <= ram_rdata;
        end
        else if (ap_wr)
        begin
            ap_reg[ap_idx[IW-1:0]] <= item.byte_value;
        end
    end

    a_load_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr_reg <= LW'(PATTERN_MAX))
        else $error("load pointer beyond pattern store");

    a_cfg_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> sweep_active_reg && !accept)
        else $error("length write did not start realignment");

endmodule

`default_nettype wire

// ----- rtl/wpm_queue.sv -----
`default_nettype none

module wpm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

endmodule

`default_nettype wire

// ----- rtl/wpm_back.sv -----
`default_nettype none

module wpm_back
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    output logic                        pop,
    input  wire wpm_tag_t               q_tag,
    input  wire logic [PATTERN_MAX-1:0] q_lanes,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output wpm_out_t                    result
);

    logic        out_valid_reg;
    wpm_out_t    out_reg;
    logic [19:0] matches_reg;
    logic [19:0] matches_next;
    logic        hit;

    assign pop          = !q_empty && (!out_valid_reg || !result_stall);
    assign hit          = &q_lanes;
    assign matches_next = (hit && (matches_reg < COUNT_LIMIT)) ? matches_reg + 20'd1
                                                                : matches_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            matches_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (q_tag.clear)
                begin
                    matches_reg <= '0;
                end
                else
                begin
                    matches_reg   <= matches_next;
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !q_tag.clear)
        begin
            out_reg.match_found    <= hit;
            out_reg.start_position <= q_tag.start_position;
            out_reg.match_count    <= matches_next;
        end
    end

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.match_found |-> out_reg.match_count != 20'd0)
        else $error("match reported with zero count");

endmodule

`default_nettype wire

// ----- rtl/wildcard_pattern_matcher.sv -----
`default_nettype none

// Wildcard pattern matcher. Pattern bytes (action 1) are appended to a pattern
// store, text bytes (action 2) shift into a window, and once the window holds
// as many bytes as the pattern length, every text byte yields one result
// transaction: whether each aligned pair of bytes is equal or either side is a
// '*' (byte 42), the 1-based start of the window, and the saturating count of
// matches since the last restart (action 0; code 3 is ignored). The block
// sustains one input transaction per clock while item_stall is low: the front
// compares all window lanes in parallel against a copy of the pattern held
// in window order, and the back reduces the lanes and keeps the count, with
// a small queue between them so that a stalled result does not hold up the
// input straight away. A text byte's result is pushed into the queue when the
// byte is taken and then into the back's output register; output stalls hold
// it in the queue. Writing the pattern length on the cfg port starts a
// realignment pass that reads the pattern store into the copy, one entry per
// clock; input is stalled and cfg_ready is low until the pass is done.
module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int          PATTERN_MAX = 64,
    parameter logic [31:0] TEXT_MAX    = 32'd1048575
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire wpm_in_t    item,
    output logic            result_valid,
    input  wire logic       result_stall,
    output wpm_out_t        result,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data
);

    localparam int TAGW = $bits(wpm_tag_t);
    localparam int QW   = TAGW + PATTERN_MAX;

    // front to queue
    logic                   push;
    wpm_tag_t               push_tag;
    logic [PATTERN_MAX-1:0] push_lanes;
    logic                   q_full;

    // queue to back
    logic                   pop;
    logic                   q_empty;
    logic [QW-1:0]          q_data;
    wpm_tag_t               q_tag;
    logic [PATTERN_MAX-1:0] q_lanes;

    wpm_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_tag   (push_tag),
        .push_lanes (push_lanes)
    );

    wpm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_tag, push_lanes}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign q_tag   = wpm_tag_t'(q_data[QW-1 -: TAGW]);
    assign q_lanes = q_data[PATTERN_MAX-1:0];

    wpm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .pop          (pop),
        .q_tag        (q_tag),
        .q_lanes      (q_lanes),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
